### design/scp_pkg.sv
`timescale 1ns / 1ps

package scp_pkg;

   localparam int unsigned HEADER_BYTES = 48;
   localparam int unsigned FOOTER_BYTES = 4;

   localparam logic [31:0] SNAP_MAGIC   = 32'h4D54_5854;
   localparam logic [31:0] SNAP_VERSION = 32'd1;
   localparam logic [31:0] FOOTER_XOR   = 32'h5A5A_5A5A;

   // header offsets of the last byte of each little-endian field
   localparam logic [5:0] OFF_MAGIC     = 6'd3;
   localparam logic [5:0] OFF_VERSION   = 6'd7;
   localparam logic [5:0] OFF_SEQ       = 6'd11;
   localparam logic [5:0] OFF_FRAME     = 6'd15;
   localparam logic [5:0] OFF_SCENE     = 6'd19;
   localparam logic [5:0] OFF_LENGTH    = 6'd23;
   localparam logic [5:0] OFF_LAYOUT_LO = 6'd27;
   localparam logic [5:0] OFF_LAYOUT_HI = 6'd31;
   localparam logic [5:0] OFF_OBJECTS   = 6'd39;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_SHORT     = 3'd1,
      ST_MAGIC     = 3'd2,
      ST_VERSION   = 3'd3,
      ST_TOO_LARGE = 3'd4,
      ST_TRUNCATED = 3'd5,
      ST_FOOTER    = 3'd6
   } status_type;

   typedef struct packed {
      logic               kind;
      logic [7:0]         payload_byte;
      status_type         status;
      logic [31:0]        sequence_number;
      logic [31:0]        frame_number;
      logic signed [31:0] scene_id;
      logic [63:0]        layout_word;
      logic signed [31:0] object_total;
      logic [16:0]        state_length;
      logic               last_of_run;
   } result_type;

   // up to two results per input word, in order: first, then second
   typedef struct packed {
      logic [1:0] num;
      result_type first;
      result_type second;
   } push_type;

endpackage

### design/scp_channel_if.sv
`timescale 1ns / 1ps

interface scp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface scp_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [7:0]         payload_byte;
   logic [2:0]         status;
   logic [31:0]        sequence_number;
   logic [31:0]        frame_number;
   logic signed [31:0] scene_id;
   logic [63:0]        layout_word;
   logic signed [31:0] object_total;
   logic [16:0]        state_length;
   logic               last_of_run;

   modport source (
      output valid, output kind, output payload_byte, output status,
      output sequence_number, output frame_number, output scene_id,
      output layout_word, output object_total, output state_length,
      output last_of_run, input ready
   );
   modport sink (
      input valid, input kind, input payload_byte, input status,
      input sequence_number, input frame_number, input scene_id,
      input layout_word, input object_total, input state_length,
      input last_of_run, output ready
   );
endinterface

### design/scp_parse.sv
`timescale 1ns / 1ps

module scp_parse import scp_pkg::*; #(
   parameter int unsigned MAX_STATE_BYTES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       end_of_file,
   output push_type   push
);

   localparam logic [32:0] MAX_LEN = 33'(MAX_STATE_BYTES);

   logic [31:0] pos_ff, pos_in, pos_upd;
   logic [31:0] seq_ff, seq_in, seq_upd;
   logic [31:0] frame_ff, frame_in, frame_upd;
   logic [31:0] scene_ff, scene_in, scene_upd;
   logic [31:0] len_ff, len_in, len_upd;
   logic [63:0] layout_ff, layout_in, layout_upd;
   logic [31:0] objects_ff, objects_in, objects_upd;
   logic [31:0] shift_ff, shift_in, shift_upd;
   status_type  error_ff, error_in, error_upd, note, status;
   logic [32:0] pay_end;
   logic        emit_payload;
   result_type  payload_res, verdict_res;

   always_comb begin
      shift_upd   = {data_byte, shift_ff[31:8]};
      pay_end     = 33'(HEADER_BYTES) + {1'b0, len_ff};
      seq_upd     = seq_ff;
      frame_upd   = frame_ff;
      scene_upd   = scene_ff;
      len_upd     = len_ff;
      layout_upd  = layout_ff;
      objects_upd = objects_ff;
      note        = ST_OK;
      emit_payload = 1'b0;

      if (pos_ff < 32'(HEADER_BYTES)) begin
         unique case (pos_ff[5:0])
            OFF_MAGIC:     if (shift_upd != SNAP_MAGIC) note = ST_MAGIC;
            OFF_VERSION:   if (shift_upd != SNAP_VERSION) note = ST_VERSION;
            OFF_SEQ:       seq_upd = shift_upd;
            OFF_FRAME:     frame_upd = shift_upd;
            OFF_SCENE:     scene_upd = shift_upd;
            OFF_LENGTH: begin
               len_upd = shift_upd;
               if ({1'b0, shift_upd} > MAX_LEN) note = ST_TOO_LARGE;
            end
            OFF_LAYOUT_LO: layout_upd[31:0] = shift_upd;
            OFF_LAYOUT_HI: layout_upd[63:32] = shift_upd;
            OFF_OBJECTS:   objects_upd = shift_upd;
            default:       ;
         endcase
      end else if ({1'b0, pos_ff} < pay_end) begin
         emit_payload = (error_ff == ST_OK);
      end else if ({1'b0, pos_ff} == pay_end + 33'(FOOTER_BYTES - 1)) begin
         if (error_ff == ST_OK && shift_upd != (seq_ff ^ FOOTER_XOR)) note = ST_FOOTER;
      end

      error_upd = (error_ff == ST_OK) ? note : error_ff;
      pos_upd   = (pos_ff == 32'hFFFF_FFFF) ? pos_ff : pos_ff + 32'd1;

      priority if (pos_upd < 32'(HEADER_BYTES + FOOTER_BYTES)) begin
         status = ST_SHORT;
      end else if (error_upd != ST_OK) begin
         status = error_upd;
      end else if ({1'b0, pos_upd} < pay_end + 33'(FOOTER_BYTES)) begin
         status = ST_TRUNCATED;
      end else begin
         status = ST_OK;
      end

      payload_res              = '0;
      payload_res.kind         = KIND_PAYLOAD;
      payload_res.payload_byte = data_byte;
      payload_res.last_of_run  = ~end_of_file;

      verdict_res                 = '0;
      verdict_res.kind            = KIND_VERDICT;
      verdict_res.status          = status;
      verdict_res.sequence_number = seq_upd;
      verdict_res.frame_number    = frame_upd;
      verdict_res.scene_id        = scene_upd;
      verdict_res.layout_word     = layout_upd;
      verdict_res.object_total    = objects_upd;
      verdict_res.state_length    = len_upd[16:0];
      verdict_res.last_of_run     = 1'b1;

      push.num    = 2'd0;
      push.first  = emit_payload ? payload_res : verdict_res;
      push.second = verdict_res;
      if (step) push.num = 2'(emit_payload) + 2'(end_of_file);

      // the verdict closes the file; start over from the reset state
      if (end_of_file) begin
         pos_in     = '0;
         seq_in     = '0;
         frame_in   = '0;
         scene_in   = '0;
         len_in     = '0;
         layout_in  = '0;
         objects_in = '0;
         shift_in   = '0;
         error_in   = ST_OK;
      end else begin
         pos_in     = pos_upd;
         seq_in     = seq_upd;
         frame_in   = frame_upd;
         scene_in   = scene_upd;
         len_in     = len_upd;
         layout_in  = layout_upd;
         objects_in = objects_upd;
         shift_in   = shift_upd;
         error_in   = error_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         seq_ff     <= '0;
         frame_ff   <= '0;
         scene_ff   <= '0;
         len_ff     <= '0;
         layout_ff  <= '0;
         objects_ff <= '0;
         shift_ff   <= '0;
         error_ff   <= ST_OK;
      end else if (step) begin
         pos_ff     <= pos_in;
         seq_ff     <= seq_in;
         frame_ff   <= frame_in;
         scene_ff   <= scene_in;
         len_ff     <= len_in;
         layout_ff  <= layout_in;
         objects_ff <= objects_in;
         shift_ff   <= shift_in;
         error_ff   <= error_in;
      end
   end

   a_eof_restarts: assert property (@(posedge clock) disable iff (reset)
      (step && end_of_file) |=> (pos_ff == '0 && error_ff == ST_OK))
      else $error("parser state not cleared after end of file");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.num == 2'd2) |-> (push.first.kind == KIND_PAYLOAD &&
                              push.second.kind == KIND_VERDICT))
      else $error("two results must be payload then verdict");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (step && !end_of_file && error_ff != ST_OK) |=> $stable(error_ff))
      else $error("first error overwritten");

endmodule

### design/scp_queue.sv
`timescale 1ns / 1ps

module scp_queue import scp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       space_ok,
   output logic       head_valid,
   input  logic       head_ready,
   output result_type head
);

   localparam int unsigned DEPTH  = 4;
   localparam int unsigned PTR_W  = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   result_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pop;

   always_comb begin
      head_valid = (count_ff != '0);
      head       = entry_ff[rd_ptr_ff];
      pop        = head_valid && head_ready;
      // room for a full pair of results, whatever leaves this cycle
      space_ok   = (count_ff <= CNT_W'(DEPTH - 2));
      wr_next    = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
      count_in   = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.num == 2'd2) entry_ff[wr_next] <= push.second;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("result queue overflow");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push.num != 2'd0) |-> space_ok)
      else $error("push into a queue without room");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !head_ready) |=> (head_valid && $stable(head)))
      else $error("waiting result word changed");

endmodule

### design/snapshot_container_parser.sv
`timescale 1ns / 1ps

// Snapshot container parser. Takes a snapshot file one byte word per cycle on
// req_chan, checks the 48-byte header and the 4-byte footer, passes payload
// bytes to rsp_chan as kind 0 words and ends each file with one kind 1
// verdict word; payload words must be discarded unless the verdict is ok.
// Rate: one input byte per clock while the output queue has room for two
// words. A byte is registered, then parsed once the queue has room, and its
// results enter a four-word output queue that drives rsp_chan. The final byte of
// a file that is also a payload byte gives two words; the queue drains one word
// per cycle while rsp_chan.ready is high, which sets the output rate, and the
// input stalls whenever the queue holds more than two words, which happens when
// the consumer holds rsp_chan.ready low.

module snapshot_container_parser import scp_pkg::*; #(
   parameter int unsigned MAX_STATE_BYTES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   scp_req_if.sink    req_chan,
   scp_rsp_if.source  rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eof_ff;
   logic       space_ok;
   logic       step;
   logic       req_take;
   push_type   push;
   result_type head;

   assign step           = in_valid_ff && space_ok;
   assign req_chan.ready = !in_valid_ff || space_ok;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (step) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_eof_ff  <= req_chan.end_of_file;
      end
   end

   scp_parse #(
      .MAX_STATE_BYTES (MAX_STATE_BYTES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (in_byte_ff),
      .end_of_file (in_eof_ff),
      .push        (push)
   );

   scp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .space_ok   (space_ok),
      .head_valid (rsp_chan.valid),
      .head_ready (rsp_chan.ready),
      .head       (head)
   );

   assign rsp_chan.kind            = head.kind;
   assign rsp_chan.payload_byte    = head.payload_byte;
   assign rsp_chan.status          = 3'(head.status);
   assign rsp_chan.sequence_number = head.sequence_number;
   assign rsp_chan.frame_number    = head.frame_number;
   assign rsp_chan.scene_id        = head.scene_id;
   assign rsp_chan.layout_word     = head.layout_word;
   assign rsp_chan.object_total    = head.object_total;
   assign rsp_chan.state_length    = head.state_length;
   assign rsp_chan.last_of_run     = head.last_of_run;

endmodule

### verif/snapshot_container_parser_tb.sv
`timescale 1ns / 1ps

module snapshot_container_parser_tb;
   import scp_pkg::*;

   localparam int unsigned MAX_LEN      = 65536;
   localparam int unsigned RANDOM_BYTES = 800;
   localparam int unsigned DRAIN_LIMIT  = 2000;
   localparam int unsigned MAX_REPORTS  = 10;

   logic clock;
   logic reset;

   scp_req_if req_chan();
   scp_rsp_if rsp_chan();

   snapshot_container_parser #(
      .MAX_STATE_BYTES(MAX_LEN)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // parser state as seen from outside
   logic [31:0] pos_count;
   logic [31:0] seq_hdr;
   logic [31:0] frame_hdr;
   logic [31:0] scene_hdr;
   logic [31:0] plen_hdr;
   logic [63:0] layout_hdr;
   logic [31:0] objects_hdr;
   logic [31:0] shift_reg;
   status_type  first_fault;

   result_type  pending_words[$];
   logic [7:0]  file_buf[$];

   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;
   int unsigned hold_off_cycles = 0;

   int unsigned mismatch_count = 0;
   int unsigned files_sent = 0;
   int unsigned bytes_sent = 0;
   int unsigned payload_words_checked = 0;
   int unsigned verdicts_checked = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_parser_state();
      pos_count   = '0;
      seq_hdr     = '0;
      frame_hdr   = '0;
      scene_hdr   = '0;
      plen_hdr    = '0;
      layout_hdr  = '0;
      objects_hdr = '0;
      shift_reg   = '0;
      first_fault = ST_OK;
   endfunction

   function automatic void note_fault(input status_type code);
      if (first_fault == ST_OK) first_fault = code;
   endfunction

   // expected words for one accepted byte
   function automatic void predict_parse(input logic [7:0] b, input logic eof);
      result_type  pay_word;
      result_type  verdict;
      logic [33:0] pay_end;
      logic [31:0] p;
      bit          has_pay;
      status_type  st;
      p        = pos_count;
      pay_end  = 34'(HEADER_BYTES) + 34'(plen_hdr);
      has_pay  = 1'b0;
      pay_word = '0;
      verdict  = '0;
      shift_reg = {b, shift_reg[31:8]};
      if (p < HEADER_BYTES) begin
         case (p[5:0])
            OFF_MAGIC:     if (shift_reg != SNAP_MAGIC) note_fault(ST_MAGIC);
            OFF_VERSION:   if (shift_reg != SNAP_VERSION) note_fault(ST_VERSION);
            OFF_SEQ:       seq_hdr = shift_reg;
            OFF_FRAME:     frame_hdr = shift_reg;
            OFF_SCENE:     scene_hdr = shift_reg;
            OFF_LENGTH: begin
               plen_hdr = shift_reg;
               if (shift_reg > MAX_LEN) note_fault(ST_TOO_LARGE);
            end
            OFF_LAYOUT_LO: layout_hdr[31:0] = shift_reg;
            OFF_LAYOUT_HI: layout_hdr[63:32] = shift_reg;
            OFF_OBJECTS:   objects_hdr = shift_reg;
            default: ;
         endcase
      end else if (34'(p) < pay_end) begin
         if (first_fault == ST_OK) begin
            has_pay = 1'b1;
            pay_word.kind = KIND_PAYLOAD;
            pay_word.payload_byte = b;
         end
      end else if (34'(p) == pay_end + 34'(FOOTER_BYTES - 1)) begin
         if (first_fault == ST_OK && shift_reg != (seq_hdr ^ FOOTER_XOR))
            note_fault(ST_FOOTER);
      end
      if (pos_count != '1) pos_count++;
      if (has_pay) begin
         pay_word.last_of_run = !eof;
         pending_words.insert(pending_words.size(), pay_word);
      end
      if (eof) begin
         if (pos_count < HEADER_BYTES + FOOTER_BYTES)
            st = ST_SHORT;
         else if (first_fault != ST_OK)
            st = first_fault;
         else if (34'(pos_count) < pay_end + 34'(FOOTER_BYTES))
            st = ST_TRUNCATED;
         else
            st = ST_OK;
         verdict.kind            = KIND_VERDICT;
         verdict.status          = st;
         verdict.sequence_number = seq_hdr;
         verdict.frame_number    = frame_hdr;
         verdict.scene_id        = scene_hdr;
         verdict.layout_word     = layout_hdr;
         verdict.object_total    = objects_hdr;
         verdict.state_length    = plen_hdr[16:0];
         verdict.last_of_run     = 1'b1;
         pending_words.insert(pending_words.size(), verdict);
         clear_parser_state();
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
   endfunction

   function automatic void check_word();
      result_type want;
      if (pending_words.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("unexpected word: kind %0d byte %h status %0d",
                     rsp_chan.kind, rsp_chan.payload_byte, rsp_chan.status);
      end else begin
         want = pending_words[0];
         pending_words.delete(0);
         if (rsp_chan.kind == KIND_VERDICT) verdicts_checked++;
         else payload_words_checked++;
         check_field("kind", 64'(want.kind), 64'(rsp_chan.kind));
         check_field("payload_byte", 64'(want.payload_byte), 64'(rsp_chan.payload_byte));
         check_field("status", 64'(want.status), 64'(rsp_chan.status));
         check_field("sequence_number", 64'(want.sequence_number),
                     64'(rsp_chan.sequence_number));
         check_field("frame_number", 64'(want.frame_number), 64'(rsp_chan.frame_number));
         check_field("scene_id", 64'(want.scene_id), 64'(rsp_chan.scene_id));
         check_field("layout_word", want.layout_word, rsp_chan.layout_word);
         check_field("object_total", 64'(want.object_total), 64'(rsp_chan.object_total));
         check_field("state_length", 64'(want.state_length), 64'(rsp_chan.state_length));
         check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_chan.last_of_run));
      end
   endfunction

   // receiver: random stall per word, plus a one-shot long hold on request
   initial begin : rsp_side
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = stalls_on ? $urandom_range(0, 12) : 0;
         stall += hold_off_cycles;
         hold_off_cycles = 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         check_word();
      end
   end

   // valid stays high after a word when the next one follows with no gap
   task automatic send_byte(input logic [7:0] b, input logic eof);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= b;
      req_chan.end_of_file <= eof;
      do @(posedge clock); while (!req_chan.ready);
      predict_parse(b, eof);
      bytes_sent++;
   endtask

   task automatic send_file();
      int unsigned i;
      for (i = 0; i < file_buf.size(); i++)
         send_byte(file_buf[i], i == file_buf.size() - 1);
      file_buf.delete();
      files_sent++;
   endtask

   function automatic void put_word(input logic [31:0] w);
      int k;
      for (k = 0; k < 4; k++) file_buf.insert(file_buf.size(), w[8*k +: 8]);
   endfunction

   function automatic void put_payload(input int unsigned n);
      int unsigned i;
      for (i = 0; i < n; i++) file_buf.insert(file_buf.size(), 8'($urandom));
   endfunction

   function automatic void put_header(input logic [31:0] magic, input logic [31:0] version,
                                      input logic [31:0] seq, input logic [31:0] frame,
                                      input logic [31:0] scene, input logic [31:0] len,
                                      input logic [63:0] layout, input logic [31:0] objects);
      put_word(magic);
      put_word(version);
      put_word(seq);
      put_word(frame);
      put_word(scene);
      put_word(len);
      put_word(layout[31:0]);
      put_word(layout[63:32]);
      put_word($urandom);
      put_word(objects);
      put_word($urandom);
      put_word($urandom);
   endfunction

   function automatic void build_good(input int unsigned len);
      logic [31:0] seq;
      seq = $urandom;
      put_header(SNAP_MAGIC, SNAP_VERSION, seq, $urandom, $urandom, len,
                 {$urandom, $urandom}, $urandom);
      put_payload(len);
      put_word(seq ^ FOOTER_XOR);
   endfunction

   task automatic test_clean_files();
      build_good(0);
      send_file();
      build_good(1);
      send_file();
      put_header(SNAP_MAGIC, SNAP_VERSION, '1, '1, 32'h8000_0000, 3, '1, 32'h7FFF_FFFF);
      file_buf.insert(file_buf.size(), 8'h00);
      file_buf.insert(file_buf.size(), 8'hFF);
      file_buf.insert(file_buf.size(), 8'hA5);
      put_word('1 ^ FOOTER_XOR);
      put_payload(3);   // trailing bytes, ignored
      send_file();
      put_header(SNAP_MAGIC, SNAP_VERSION, '0, '0, 32'h7FFF_FFFF, 0, '0, 32'h8000_0000);
      put_word(FOOTER_XOR);
      send_file();
   endtask

   task automatic test_short_files();
      file_buf.insert(file_buf.size(), 8'h54);
      send_file();
      put_header(SNAP_MAGIC, SNAP_VERSION, $urandom, $urandom, $urandom, 0, '1, $urandom);
      put_payload(3);
      send_file();
      put_word(~SNAP_MAGIC);
      send_file();
      put_header(SNAP_MAGIC, SNAP_VERSION, $urandom, $urandom, $urandom, 2, '0, $urandom);
      while (file_buf.size() > 20) void'(file_buf.pop_back());
      send_file();
   endtask

   task automatic test_header_faults();
      put_header(~SNAP_MAGIC, SNAP_VERSION, 0, 1, 2, 2, 64'd3, 4);
      put_payload(2);
      put_word(FOOTER_XOR);
      send_file();
      put_header(SNAP_MAGIC, 32'd0, 5, 6, 7, 2, 64'd8, 9);
      put_payload(2);
      put_word(5 ^ FOOTER_XOR);
      send_file();
      put_header(SNAP_MAGIC, 32'h0000_0101, 5, 6, 7, 1, 64'd8, 9);
      put_payload(1);
      put_word(5 ^ FOOTER_XOR);
      send_file();
      // magic outranks version
      put_header(32'h0, 32'd2, 1, 1, 1, 0, 64'd1, 1);
      put_word(1 ^ FOOTER_XOR);
      send_file();
      put_header(SNAP_MAGIC, SNAP_VERSION, 1, 2, 3, MAX_LEN + 1, 64'd4, 5);
      put_payload(20);
      send_file();
      put_header(SNAP_MAGIC, SNAP_VERSION, 1, 2, 3, '1, 64'd4, 5);
      put_payload(8);
      send_file();
      // version error hides a later footer error
      put_header(SNAP_MAGIC, 32'd7, 1, 2, 3, 1, 64'd4, 5);
      put_payload(1);
      put_word(32'h0);
      send_file();
   endtask

   task automatic test_footer_and_length();
      build_good(4);
      file_buf[file_buf.size() - 1] ^= 8'h80;
      send_file();
      build_good(3);
      file_buf[file_buf.size() - 4] ^= 8'h01;
      put_payload(5);
      send_file();
      // ends on a payload byte: payload word and verdict from one byte
      build_good(10);
      while (file_buf.size() > HEADER_BYTES + 6) void'(file_buf.pop_back());
      send_file();
      build_good(4);
      void'(file_buf.pop_back());
      send_file();
      build_good(0);
      while (file_buf.size() > HEADER_BYTES) void'(file_buf.pop_back());
      send_file();
   endtask

   // largest allowed length passes the header check; the file ends early
   task automatic test_max_length();
      put_header(SNAP_MAGIC, SNAP_VERSION, $urandom, $urandom, $urandom, MAX_LEN,
                 {$urandom, $urandom}, $urandom);
      put_payload(20);
      send_file();
   endtask

   task automatic test_back_pressure();
      gaps_on = 1'b0;
      hold_off_cycles = 300;
      build_good(100);
      send_file();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_files();
      int unsigned random_bytes;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      int unsigned idx;
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         pick = $urandom_range(0, 9);
         len  = $urandom_range(0, 40);
         if (pick <= 5) begin
            build_good(len);
            if ($urandom_range(0, 3) == 0) put_payload($urandom_range(1, 4));
         end else if (pick == 6) begin
            build_good(len);
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut) void'(file_buf.pop_back());
         end else if (pick == 7) begin
            build_good(len);
            idx = $urandom_range(0, file_buf.size() - 1);
            file_buf[idx] ^= 8'(1 << $urandom_range(0, 7));
         end else if (pick == 8) begin
            put_header(SNAP_MAGIC, SNAP_VERSION, $urandom, $urandom, $urandom,
                       $urandom_range(MAX_LEN + 1, 32'hFFFF_FFFF), {$urandom, $urandom},
                       $urandom);
            put_payload($urandom_range(0, 20));
         end else begin
            put_payload($urandom_range(1, 80));
         end
         random_bytes += file_buf.size();
         send_file();
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   initial begin : stimulus
      int unsigned waited;
      clear_parser_state();
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.data_byte   <= '0;
      req_chan.end_of_file <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_clean_files();
      test_short_files();
      test_header_faults();
      test_footer_and_length();
      test_max_length();
      test_back_pressure();
      test_random_files();

      req_chan.valid <= 1'b0;
      for (waited = 0; pending_words.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_words.size() != 0) begin
         mismatch_count += pending_words.size();
         $display("%0d expected words never arrived", pending_words.size());
      end

      $display("%0d files, %0d bytes: clean, short, header faults, footer, truncation,",
               files_sent, bytes_sent);
      $display("%s; %0d payload words, %0d verdicts checked, %0d errors",
               "largest length, long output hold and a random mix",
               payload_words_checked, verdicts_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("timed out with %0d words outstanding", pending_words.size());
      $display("status: fail");
      $finish;
   end

endmodule
